// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/krt_pkg.sv
package krt_pkg;

   // Field widths
   localparam int KeyWidth   = 27;
   localparam int GradeWidth = 10;
   localparam int PosWidth   = 5;
   localparam int CountWidth = 6;

   localparam logic [GradeWidth-1:0] GRADE_MAX = 10'd1000;

   // Commands
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_FOUND    = 2'd2;
   localparam logic [1:0] ST_MISSING  = 2'd3;

   typedef struct packed {
      logic                  command;
      logic [KeyWidth-1:0]   key;
      logic [GradeWidth-1:0] first_grade;
      logic [GradeWidth-1:0] second_grade;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [PosWidth-1:0]   position;
      logic [CountWidth-1:0] stored_count;
   } rsp_type;

   // One table entry
   typedef struct packed {
      logic [KeyWidth-1:0]   key;
      logic [GradeWidth-1:0] first_grade;
      logic [GradeWidth-1:0] second_grade;
   } record_type;

   // Table write request
   typedef struct packed {
      logic       we;
      record_type rec;
   } mem_wr_type;

   // Saturate a grade to the top of its range
   function automatic logic [GradeWidth-1:0] clamp_grade(input logic [GradeWidth-1:0] g);
      return (g > GRADE_MAX) ? GRADE_MAX : g;
   endfunction

endpackage

// File: rtl/core/krt_mem.sv
module krt_mem #(
   parameter  int DEPTH = 32,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  krt_pkg::mem_wr_type    wr,
   input  logic [AW-1:0]          waddr,
   input  logic [AW-1:0]          raddr,
   output krt_pkg::record_type    rdata
);

   krt_pkg::record_type mem_ff [DEPTH];
   krt_pkg::record_type rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem_ff[waddr] <= wr.rec;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/krt_seq.sv
`include "assert_macros.svh"

module krt_seq #(
   parameter  int DEPTH = 32,
   localparam int AW    = $clog2(DEPTH),
   localparam int CW    = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  krt_pkg::req_type    req_payload,
   input  logic                sorted_mode,
   output logic                done_valid,
   output krt_pkg::rsp_type    done_result,
   input  logic                done_take,
   output krt_pkg::mem_wr_type mem_wr,
   output logic [AW-1:0]       mem_waddr,
   output logic [AW-1:0]       mem_raddr,
   input  krt_pkg::record_type mem_rdata
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SHIFT = 4'b0010,
      S_SCAN  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       slot_ff, slot_in;
   krt_pkg::record_type item_ff, item_in;
   krt_pkg::rsp_type    result_ff, result_in;

   logic                full;
   logic                greater;
   logic                match;
   logic                last;
   logic [CW-1:0]       count_dec;
   logic [CW-1:0]       count_inc;
   krt_pkg::record_type incoming;
   logic                reject_start;
   logic                reject_seen;

   assign full      = (count_ff == CW'(DEPTH));
   assign count_dec = count_ff - CW'(1);
   assign count_inc = count_ff + CW'(1);
   // Key compares against the entry just read
   assign greater   = (mem_rdata.key > item_ff.key);
   assign match     = (mem_rdata.key == item_ff.key);
   assign last      = ((CW'(slot_ff) + CW'(1)) == count_ff);

   assign incoming.key          = req_payload.key;
   assign incoming.first_grade  = krt_pkg::clamp_grade(req_payload.first_grade);
   assign incoming.second_grade = krt_pkg::clamp_grade(req_payload.second_grade);

   assign req_stall   = (state_ff != S_IDLE);
   assign done_valid  = (state_ff == S_DONE);
   assign done_result = result_ff;

   // Full-table insert taken, and its reject result
   assign reject_start = (state_ff == S_IDLE) && req_valid && full &&
                         (req_payload.command == krt_pkg::CMD_INSERT);
   assign reject_seen  = (state_ff == S_DONE) && (result_ff.status == krt_pkg::ST_FULL);

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      slot_in    = slot_ff;
      item_in    = item_ff;
      result_in  = result_ff;
      mem_wr.we  = 1'b0;
      mem_wr.rec = item_ff;
      mem_waddr  = slot_ff;
      mem_raddr  = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = incoming;
               if (req_payload.command == krt_pkg::CMD_INSERT) begin
                  if (full) begin
                     result_in = '{krt_pkg::ST_FULL, '0, 6'(count_ff)};
                     state_in  = S_DONE;
                  end else if (!sorted_mode || count_ff == '0) begin
                     // Append at the end
                     mem_wr.we  = 1'b1;
                     mem_wr.rec = incoming;
                     mem_waddr  = count_ff[AW-1:0];
                     count_in   = count_inc;
                     result_in  = '{krt_pkg::ST_INSERTED, 5'(count_ff), 6'(count_inc)};
                     state_in   = S_DONE;
                  end else begin
                     // Start the downward walk at the top entry
                     mem_raddr = count_dec[AW-1:0];
                     slot_in   = count_ff[AW-1:0];
                     state_in  = S_SHIFT;
                  end
               end else begin
                  result_in = '{krt_pkg::ST_MISSING, '0, 6'(count_ff)};
                  slot_in   = '0;
                  if (count_ff == '0) begin
                     state_in = S_DONE;
                  end else begin
                     mem_raddr = '0;
                     state_in  = S_SCAN;
                  end
               end
            end
         end
         S_SHIFT: begin
            mem_wr.we = 1'b1;
            if (slot_ff != '0 && greater) begin
               // Move the larger entry up one place, fetch the next one down
               mem_wr.rec = mem_rdata;
               slot_in    = slot_ff - AW'(1);
               mem_raddr  = slot_ff - AW'(2);
            end else begin
               mem_wr.rec = item_ff;
               count_in   = count_inc;
               result_in  = '{krt_pkg::ST_INSERTED, 5'(slot_ff), 6'(count_inc)};
               state_in   = S_DONE;
            end
         end
         S_SCAN: begin
            if (match) begin
               result_in = '{krt_pkg::ST_FOUND, 5'(slot_ff), 6'(count_ff)};
            end
            // Sorted mode stops at the first hit, append mode keeps the last
            if ((match && sorted_mode) || last) begin
               state_in = S_DONE;
            end else begin
               slot_in   = slot_ff + AW'(1);
               mem_raddr = slot_ff + AW'(1);
            end
         end
         S_DONE: begin
            if (done_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      slot_ff   <= slot_in;
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   // Checks
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CW'(DEPTH))
   `ASSERT_ALWAYS(a_count_step, clock, reset, count_in == count_ff || count_in == count_inc)
   `ASSERT_NEXT(a_full_reject, clock, reset, reject_start, reject_seen && $stable(count_ff))

endmodule

// File: rtl/core/keyed_record_table_insert_search_top.sv
// Keyed record table: insert and search over up to DEPTH records.
// Request channel (req_valid / req_stall / req_payload): one beat is one
// command, insert a record or look up a key. The block raises req_stall
// while it works on a beat, so one command is in flight at a time.
// Response channel (rsp_valid / rsp_stall / rsp_payload): exactly one beat
// per request, carrying status, position and the stored record count.
// Config channel (csr_valid / csr_ready / csr_data): sorted_mode, always
// ready; write it only while the block is idle.
// Requests walk the record memory (one read, one write port) one entry per
// cycle, N = records stored: append insert, rejected insert and lookup on an
// empty table need no walk; sorted insert moves up to N entries; lookup
// scans up to N entries.
// A finished result sits in the response register; if rsp_stall holds it,
// the next result waits in the sequencer and the request side stays stalled.
// Reset (synchronous) empties the table, sets sorted_mode to 1 and drops
// any pending response. Memory contents need no clearing.
module keyed_record_table_insert_search_top #(
   parameter int DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  krt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output krt_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   localparam int AW = $clog2(DEPTH);

   logic                sorted_mode_ff, sorted_mode_in;
   logic                rsp_valid_ff, rsp_valid_in;
   krt_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic                done_valid;
   logic                done_take;
   krt_pkg::rsp_type    done_result;
   krt_pkg::mem_wr_type mem_wr;
   logic [AW-1:0]       mem_waddr;
   logic [AW-1:0]       mem_raddr;
   krt_pkg::record_type mem_rdata;

   // Config register
   assign csr_ready      = 1'b1;
   assign sorted_mode_in = (csr_valid && csr_ready) ? csr_data : sorted_mode_ff;

   // Output register loads when empty or draining
   assign done_take    = done_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = done_take ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = done_take ? done_result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sorted_mode_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         sorted_mode_ff <= sorted_mode_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   krt_seq #(.DEPTH(DEPTH)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .sorted_mode (sorted_mode_ff),
      .done_valid  (done_valid),
      .done_result (done_result),
      .done_take   (done_take),
      .mem_wr      (mem_wr),
      .mem_waddr   (mem_waddr),
      .mem_raddr   (mem_raddr),
      .mem_rdata   (mem_rdata)
   );

   krt_mem #(.DEPTH(DEPTH)) u_mem (
      .clock (clock),
      .wr    (mem_wr),
      .waddr (mem_waddr),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule
